// ===== hdl/tcce_pkg.sv =====
// Shared types, constants and helpers of the text console cursor engine.
package tcce_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_FILL = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUT,
    ST_SCR_PRIME,
    ST_SCROLL,
    ST_FILL,
    ST_READ,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // latch the input transaction
    logic put;        // update cursor and write the cursor cell
    logic home;       // cursor to top left
    logic fill_wr;    // write fill value at sweep counter, advance
    logic fill_zero;  // fill value is zero (power-up clear)
    logic scr_prime;  // fetch first cell of second row
    logic scr_wr;     // move one character up a row, advance
    logic rd_cell;    // fetch the requested cell
    logic out_load;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scroll;     // the pending put pushes the cursor past the last row
    logic sweep_last; // sweep counter sits on the last cell
    logic out_free;   // result register can take a new transaction
  } sts_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
  endfunction

endpackage

// ===== hdl/tcce_ctrl.sv =====
// Controller state machine of the text console cursor engine.
module tcce_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  tcce_pkg::op_t    in_op,
  input  tcce_pkg::sts_t   sts,
  output logic             in_tready,
  output tcce_pkg::cmd_t   cmd
);

  tcce_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcce_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      tcce_pkg::ST_CLEAR: begin
        cmd.fill_wr   = 1'b1;
        cmd.fill_zero = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = tcce_pkg::ST_IDLE;
        end
      end
      tcce_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take = 1'b1;
          case (in_op)
            tcce_pkg::OP_PUT:  state_nxt = tcce_pkg::ST_PUT;
            tcce_pkg::OP_FILL: state_nxt = tcce_pkg::ST_FILL;
            tcce_pkg::OP_READ: state_nxt = tcce_pkg::ST_READ;
            default:           state_nxt = tcce_pkg::ST_DONE;
          endcase
        end
      end
      tcce_pkg::ST_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = sts.scroll ? tcce_pkg::ST_SCR_PRIME : tcce_pkg::ST_DONE;
      end
      tcce_pkg::ST_SCR_PRIME: begin
        cmd.scr_prime = 1'b1;
        state_nxt     = tcce_pkg::ST_SCROLL;
      end
      tcce_pkg::ST_SCROLL: begin
        cmd.scr_wr = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = tcce_pkg::ST_DONE;
        end
      end
      tcce_pkg::ST_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.sweep_last) begin
          cmd.home  = 1'b1;
          state_nxt = tcce_pkg::ST_DONE;
        end
      end
      tcce_pkg::ST_READ: begin
        cmd.rd_cell = 1'b1;
        state_nxt   = tcce_pkg::ST_DONE;
      end
      tcce_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = tcce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcce_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/tcce_dp.sv =====
// Datapath of the text console cursor engine: cell stores, cursor, sweep counter, result register.
module tcce_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcce_pkg::cmd_t                cmd,
  input  logic [7:0]                    in_ch,
  input  logic [7:0]                    in_attr,
  input  logic [tcce_pkg::ADDR_W-1:0]   in_cell_index,
  input  logic                          in_is_read,
  input  logic                          out_tready,
  output tcce_pkg::sts_t                sts,
  output logic                          out_valid,
  output logic [tcce_pkg::COL_W-1:0]    out_cursor_col,
  output logic [tcce_pkg::ROW_W-1:0]    out_cursor_row,
  output logic [tcce_pkg::ADDR_W-1:0]   out_cursor_pos,
  output logic [7:0]                    out_read_char,
  output logic [7:0]                    out_read_attr
);

  localparam int AW = tcce_pkg::ADDR_W;

  logic [7:0] char_mem [tcce_pkg::CELLS];
  logic [7:0] attr_mem [tcce_pkg::CELLS];

  // Control state
  logic [tcce_pkg::COL_W-1:0] col_r, col_nxt;
  logic [tcce_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [AW-1:0]              cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // Payload
  logic [7:0]    ch_r, attr_r;
  logic [AW-1:0] idx_r;
  logic          rd_ok_r;
  logic [7:0]    q_char_r, q_attr_r;
  logic [tcce_pkg::COL_W-1:0] o_col_r;
  logic [tcce_pkg::ROW_W-1:0] o_row_r;
  logic [AW-1:0]              o_pos_r;
  logic [7:0]                 o_char_r, o_attr_r;

  // Put decode
  logic [tcce_pkg::COL_W:0]   pc;
  logic [tcce_pkg::ROW_W:0]   pr;
  logic                       p_we;
  logic [7:0]                 p_char;
  logic [tcce_pkg::COL_W-1:0] p_wcol;
  logic                       p_scroll;

  // Memory ports
  logic          we_char, we_attr, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_char, wr_attr;
  logic [AW:0]   scr_next;

  always_comb begin
    pc     = {1'b0, col_r};
    pr     = {1'b0, row_r};
    p_we   = 1'b0;
    p_char = ch_r;
    p_wcol = col_r;
    case (ch_r)
      tcce_pkg::CH_LF: begin
        pc = '0;
        pr = pr + 1'b1;
      end
      tcce_pkg::CH_CR: begin
        pc = '0;
      end
      tcce_pkg::CH_NUL: begin
      end
      tcce_pkg::CH_BS: begin
        if (col_r != '0) begin
          pc     = pc - 1'b1;
          p_wcol = col_r - 1'b1;
          p_we   = 1'b1;
          p_char = 8'h00;
        end
      end
      default: begin
        pc   = pc + 1'b1;
        p_we = 1'b1;
      end
    endcase
    if (pc >= (tcce_pkg::COL_W+1)'(tcce_pkg::COLS)) begin
      pc = '0;
      pr = pr + 1'b1;
    end
    p_scroll = (pr >= (tcce_pkg::ROW_W+1)'(tcce_pkg::ROWS));
    if (p_scroll) begin
      pr = (tcce_pkg::ROW_W+1)'(tcce_pkg::ROWS - 1);
    end
  end

  // Next read while scrolling: one row below the cell after the current one.
  assign scr_next = {1'b0, cnt_r} + (AW+1)'(tcce_pkg::COLS + 1);

  always_comb begin
    we_char = 1'b0;
    we_attr = 1'b0;
    wr_addr = cnt_r;
    wr_char = 8'h00;
    wr_attr = 8'h00;
    rd_en   = 1'b0;
    rd_addr = idx_r;
    if (cmd.put) begin
      we_char = p_we;
      we_attr = p_we;
      wr_addr = tcce_pkg::cell_addr(row_r, p_wcol);
      wr_char = p_char;
      wr_attr = attr_r;
    end else if (cmd.fill_wr) begin
      we_char = 1'b1;
      we_attr = 1'b1;
      wr_char = cmd.fill_zero ? 8'h00 : ch_r;
      wr_attr = cmd.fill_zero ? 8'h00 : attr_r;
    end else if (cmd.scr_wr) begin
      we_char = 1'b1;
      wr_char = (cnt_r < AW'(tcce_pkg::CELLS - tcce_pkg::COLS)) ? q_char_r : 8'h00;
    end
    if (cmd.scr_prime) begin
      rd_en   = 1'b1;
      rd_addr = AW'(tcce_pkg::COLS);
    end else if (cmd.scr_wr) begin
      rd_en   = 1'b1;
      // past the end the data is not used: the last row is cleared
      rd_addr = (scr_next < (AW+1)'(tcce_pkg::CELLS)) ? scr_next[AW-1:0] : '0;
    end else if (cmd.rd_cell) begin
      rd_en   = 1'b1;
      rd_addr = rd_ok_r ? idx_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we_char) begin
      char_mem[wr_addr] <= wr_char;
    end
    if (we_attr) begin
      attr_mem[wr_addr] <= wr_attr;
    end
    if (rd_en) begin
      q_char_r <= char_mem[rd_addr];
      q_attr_r <= attr_mem[rd_addr];
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.put) begin
      col_nxt = pc[tcce_pkg::COL_W-1:0];
      row_nxt = pr[tcce_pkg::ROW_W-1:0];
    end else if (cmd.home) begin
      col_nxt = '0;
      row_nxt = '0;
    end
    cnt_nxt = cnt_r;
    if (cmd.take || cmd.scr_prime) begin
      cnt_nxt = '0;
    end else if (cmd.fill_wr || cmd.scr_wr) begin
      cnt_nxt = sts.sweep_last ? '0 : cnt_r + 1'b1;
    end
    out_valid_nxt = out_valid_r && !out_tready;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ch_r    <= in_ch;
      attr_r  <= in_attr;
      idx_r   <= in_cell_index;
      rd_ok_r <= in_is_read && (in_cell_index < AW'(tcce_pkg::CELLS));
    end
    if (cmd.out_load) begin
      o_col_r  <= col_r;
      o_row_r  <= row_r;
      o_pos_r  <= tcce_pkg::cell_addr(row_r, col_r);
      o_char_r <= rd_ok_r ? q_char_r : 8'h00;
      o_attr_r <= rd_ok_r ? q_attr_r : 8'h00;
    end
  end

  assign sts.scroll     = p_scroll;
  assign sts.sweep_last = (cnt_r == AW'(tcce_pkg::CELLS - 1));
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_valid      = out_valid_r;
  assign out_cursor_col = o_col_r;
  assign out_cursor_row = o_row_r;
  assign out_cursor_pos = o_pos_r;
  assign out_read_char  = o_char_r;
  assign out_read_attr  = o_attr_r;

endmodule

// ===== hdl/text_console_cursor_engine_unit.sv =====
// Top level of the text console cursor engine: 80 by 25 character and attribute stores.
// Flow: a put or read goes through its own state, then DONE loads the result register;
//   an unused op goes to DONE at once; scrolling puts and fills first sweep all cells.
// Throughput: one transaction at a time; the next is taken once the result is loaded;
//   scroll and fill write one cell per cycle, and a stalled result holds the input off.
// Reset: cursor goes home, then a clearing pass zeroes both stores, in_tready low.
module text_console_cursor_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // op[1:0], ch[9:2], attr[17:10], cell_index[28:18], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // cursor_col[6:0], cursor_row[11:7], cursor_pos[22:12],
                                  // read_char[30:23], read_attr[38:31], zero
);

  tcce_pkg::cmd_t cmd;
  tcce_pkg::sts_t sts;
  tcce_pkg::op_t  in_op;

  logic [tcce_pkg::COL_W-1:0]  cursor_col;
  logic [tcce_pkg::ROW_W-1:0]  cursor_row;
  logic [tcce_pkg::ADDR_W-1:0] cursor_pos;
  logic [7:0]                  read_char;
  logic [7:0]                  read_attr;

  // Unpack the op code of the incoming transaction.
  assign in_op = tcce_pkg::op_t'(in_tdata[1:0]);

  // Sequence each transaction: put, fill, read, scroll and the power-up clear.
  tcce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_op),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  // Hold the stores, the cursor and the result register.
  tcce_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_ch          (in_tdata[9:2]),
    .in_attr        (in_tdata[17:10]),
    .in_cell_index  (in_tdata[28:18]),
    .in_is_read     (in_op == tcce_pkg::OP_READ),
    .out_tready     (out_tready),
    .sts            (sts),
    .out_valid      (out_tvalid),
    .out_cursor_col (cursor_col),
    .out_cursor_row (cursor_row),
    .out_cursor_pos (cursor_pos),
    .out_read_char  (read_char),
    .out_read_attr  (read_attr)
  );

  // Pack the result fields, lowest field first.
  assign out_tdata = {1'b0, read_attr, read_char, cursor_pos, cursor_row, cursor_col};

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking stream testbench for the text console cursor engine.
`timescale 1ns / 1ps

module tb_top;
  import tcce_pkg::*;

  // Longest quiet stretch is a scroll or fill sweep on top of a receiver stall;
  // allow many times that before calling the run hung.
  localparam int unsigned IDLE_LIMIT    = 50000;
  localparam int unsigned RANDOM_ITEMS  = 400;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned IDX_MAX       = (1 << ADDR_W) - 1;

  // One console command as queued for the driver.
  typedef struct {
    op_t             op;
    logic [7:0]      ch;
    logic [7:0]      attr;
    logic [ADDR_W-1:0] idx;
    bit              drain_first;  // hold until every cursor report is back
  } console_req_t;

  // Cursor report laid out exactly as out_tdata[38:0], lowest field last.
  typedef struct packed {
    logic [7:0]        rd_attr;
    logic [7:0]        rd_char;
    logic [ADDR_W-1:0] pos;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cursor_report_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;  // op[1:0], ch[9:2], attr[17:10], cell_index[28:18], zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // cursor_col[6:0], cursor_row[11:7], cursor_pos[22:12],
                                 // read_char[30:23], read_attr[38:31], zero

  // Commands waiting for the driver, and cursor reports waiting for the DUT.
  console_req_t   pending_q[$];
  cursor_report_t reports_q[$];

  // Shadow copy of the screen and cursor.
  logic [7:0] screen_chars [CELLS];
  logic [7:0] screen_attrs [CELLS];
  int         cur_col;
  int         cur_row;

  int unsigned    fail_count = 0;
  bit             in_taken   = 1'b0;
  console_req_t   next_req;
  cursor_report_t got_rep;
  cursor_report_t want_rep;
  int unsigned    burst_left = 0;
  int unsigned    gap_left   = 0;
  int unsigned    sink_tick  = 0;
  int unsigned    sink_mode  = 0;
  int unsigned    idle_cycles = 0;

  text_console_cursor_engine_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Apply one command to the shadow screen and return the cursor report it causes.
  function automatic cursor_report_t console_apply(input op_t op, input logic [7:0] ch,
                                                   input logic [7:0] attr,
                                                   input logic [ADDR_W-1:0] idx);
    cursor_report_t rep;
    int cell_no;
    int i;
    rep     = '0;
    cell_no = cur_row * COLS + cur_col;
    case (op)
      OP_PUT: begin
        case (ch)
          CH_LF: begin
            cur_col = 0;
            cur_row = cur_row + 1;
          end
          CH_CR:  cur_col = 0;
          CH_NUL: ;
          CH_BS: begin
            // Step left and blank the cell; at column 0 leave everything alone.
            if (cur_col > 0) begin
              cur_col = cur_col - 1;
              cell_no = cur_row * COLS + cur_col;
              screen_chars[cell_no] = 8'h00;
              screen_attrs[cell_no] = attr;
            end
          end
          default: begin
            screen_chars[cell_no] = ch;
            screen_attrs[cell_no] = attr;
            cur_col = cur_col + 1;
          end
        endcase
        // Wrap at the right margin.
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row = cur_row + 1;
        end
        // Scroll moves characters only; attributes stay where they are.
        if (cur_row >= ROWS) begin
          for (i = 0; i < CELLS - COLS; i++) screen_chars[i] = screen_chars[i + COLS];
          for (i = CELLS - COLS; i < CELLS; i++) screen_chars[i] = 8'h00;
          cur_row = ROWS - 1;
        end
      end
      OP_FILL: begin
        for (i = 0; i < CELLS; i++) begin
          screen_chars[i] = ch;
          screen_attrs[i] = attr;
        end
        cur_col = 0;
        cur_row = 0;
      end
      OP_READ: begin
        // Out-of-range index reads back zero.
        if (idx < CELLS) begin
          rep.rd_char = screen_chars[idx];
          rep.rd_attr = screen_attrs[idx];
        end
      end
      default: ;
    endcase
    rep.col = COL_W'(cur_col);
    rep.row = ROW_W'(cur_row);
    rep.pos = ADDR_W'(cur_row * COLS + cur_col);
    return rep;
  endfunction

  task automatic queue_req(input op_t op, input logic [7:0] ch, input logic [7:0] attr,
                           input int unsigned idx, input bit drain_first = 1'b0);
    console_req_t r;
    r.op          = op;
    r.ch          = ch;
    r.attr        = attr;
    r.idx         = ADDR_W'(idx);
    r.drain_first = drain_first;
    pending_q.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Stimulus, reset and end of run.
  initial begin
    int unsigned made;
    int unsigned line_no;
    int unsigned len;
    int unsigned sel;
    int unsigned k;
    int unsigned idx;
    made    = 0;
    line_no = 0;

    // Directed: store cleared at reset, read range edges, control codes, wrap-free
    // cursor moves, unused op and fills with extreme bytes.
    queue_req(OP_READ, 8'h00, 8'h00, 0);
    queue_req(OP_READ, 8'hFF, 8'hFF, CELLS - 1);
    queue_req(OP_READ, 8'h00, 8'h00, CELLS);
    queue_req(OP_READ, 8'h00, 8'h00, IDX_MAX);
    queue_req(OP_PUT, CH_BS, 8'h5A, 0);
    queue_req(OP_PUT, CH_NUL, 8'hFF, 0);
    queue_req(OP_PUT, 8'h41, 8'hFF, 0);
    queue_req(OP_PUT, 8'hFF, 8'h00, 0);
    queue_req(OP_PUT, 8'h01, 8'hA5, 0);
    queue_req(OP_PUT, CH_BS, 8'h3C, 0);
    queue_req(OP_READ, 8'h00, 8'h00, 1);
    queue_req(OP_READ, 8'h00, 8'h00, 2);
    queue_req(OP_PUT, CH_CR, 8'h00, 0);
    queue_req(OP_PUT, CH_LF, 8'h00, 0);
    queue_req(OP_PUT, 8'h7E, 8'h0F, 0);
    queue_req(OP_READ, 8'h00, 8'h00, COLS);
    queue_req(OP_NONE, 8'hFF, 8'hFF, IDX_MAX);
    queue_req(OP_FILL, 8'h20, 8'h07, 0, 1'b1);
    queue_req(OP_READ, 8'h00, 8'h00, CELLS / 2);
    queue_req(OP_PUT, 8'h80, 8'h70, 0);
    queue_req(OP_FILL, 8'hFF, 8'hFF, 0);
    queue_req(OP_READ, 8'h00, 8'h00, CELLS - 1);
    queue_req(OP_FILL, 8'h00, 8'h00, 0);
    queue_req(OP_READ, 8'h00, 8'h00, 0);

    // Random: mostly lines of text with reads and edits mixed in, so that the
    // cursor wraps and the screen scrolls; some fills and unused ops as noise.
    while (made < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        queue_req(OP_FILL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0,
                  $urandom_range(0, 1));
        made++;
      end else if (sel < 4) begin
        queue_req(OP_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  $urandom_range(0, IDX_MAX));
      end else begin
        // Force one long line early so a wrap is likely.
        if (line_no == 2 || $urandom_range(0, 99) < 4) len = $urandom_range(COLS - 3, COLS + 4);
        else len = $urandom_range(0, 6);
        for (k = 0; k < len; k++) begin
          sel = $urandom_range(0, 99);
          if (sel < 15) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) idx = $urandom_range(0, CELLS - 1);
            else if (sel < 9) idx = $urandom_range(CELLS - 3 * COLS, CELLS - 1);
            else idx = $urandom_range(0, IDX_MAX);
            queue_req(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), idx);
          end else if (sel < 23) begin
            queue_req(OP_PUT, CH_BS, 8'($urandom_range(0, 255)), $urandom_range(0, IDX_MAX));
          end else if (sel < 26) begin
            queue_req(OP_PUT, CH_NUL, 8'($urandom_range(0, 255)), 0);
          end else begin
            queue_req(OP_PUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      $urandom_range(0, IDX_MAX));
          end
          made++;
        end
        // End the line: newline, CR then newline, bare CR, or nothing.
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
          queue_req(OP_PUT, CH_CR, 8'($urandom_range(0, 255)), 0);
          made++;
        end
        if (sel < 75) begin
          queue_req(OP_PUT, CH_LF, 8'($urandom_range(0, 255)), 0,
                    $urandom_range(0, 49) == 0);
          made++;
        end else if (sel < 85) begin
          queue_req(OP_PUT, CH_CR, 8'($urandom_range(0, 255)), 0);
          made++;
        end
        line_no++;
      end
    end

    foreach (screen_chars[i]) begin
      screen_chars[i] = 8'h00;
      screen_attrs[i] = 8'h00;
    end
    cur_col = 0;
    cur_row = 0;

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Drain: everything sent, nothing outstanding, then let the pipeline settle.
    // Look at the rising edge, where the sender's outputs are stable.
    while (pending_q.size() != 0 || in_tvalid || reports_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && reports_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Sender: bursts of commands with random gaps; hold tvalid until the
  // transaction is taken, and hold off a marked command until all reports are in.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // hold the current transaction
    end else if (gap_left != 0) begin
      in_tvalid <= 1'b0;
      gap_left  = gap_left - 1;
    end else if (pending_q.size() == 0 ||
                 (pending_q[0].drain_first && reports_q.size() != 0)) begin
      in_tvalid <= 1'b0;
    end else begin
      next_req = pending_q.pop_front();
      in_tvalid <= 1'b1;
      in_tdata  <= {3'b000, next_req.idx, next_req.attr, next_req.ch, next_req.op};
      if (burst_left <= 1) begin
        if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(40, 80);
        else burst_left = $urandom_range(1, 12);
        gap_left = $urandom_range(1, 10);
      end else begin
        burst_left = burst_left - 1;
      end
    end
  end

  // Receiver: switch between always ready, light, heavy and periodic backpressure.
  always @(negedge clk) begin
    sink_tick = sink_tick + 1;
    if (sink_tick % 64 == 0) sink_mode = $urandom_range(0, 3);
    case (sink_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (sink_tick % 7) >= 3;
    endcase
  end

  // Monitor: check the oldest report first, then predict the one just accepted,
  // since a report never comes back in the cycle its command goes in.
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (reports_q.size() == 0) begin
          $error("result transaction with no command outstanding");
          fail_count++;
        end else begin
          want_rep = reports_q.pop_front();
          got_rep  = cursor_report_t'(out_tdata[38:0]);
          check_field("cursor_col", want_rep.col, got_rep.col);
          check_field("cursor_row", want_rep.row, got_rep.row);
          check_field("cursor_pos", want_rep.pos, got_rep.pos);
          check_field("read_char", want_rep.rd_char, got_rep.rd_char);
          check_field("read_attr", want_rep.rd_attr, got_rep.rd_attr);
        end
      end
      if (in_tvalid && in_tready)
        reports_q.push_back(console_apply(op_t'(in_tdata[1:0]), in_tdata[9:2],
                                          in_tdata[17:10], in_tdata[28:18]));
    end
  end

  // Watchdog: end the run if neither side moves a transaction for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
